// File: src/chip8_instruction_core_defines.svh
// assertion macros shared by the checker of chip8_instruction_core
// needs signals named clk and rst in the scope that uses them
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define C8_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define C8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/c8ic_pkg.sv
// shared constants, types and font table of the chip-8 instruction core
// no dependencies
package c8ic_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam logic [15:0] START_PC = 16'h0200;
  localparam int FONT_BYTES  = 80;

  // request kinds
  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_ROW   = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_PC_RANGE  = 3'd1;
  localparam logic [2:0] STAT_MCALL     = 3'd2;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd4;

  // datapath commands
  localparam logic [4:0] CMD_NOP    = 5'd0;
  localparam logic [4:0] CMD_CLEAR  = 5'd1;
  localparam logic [4:0] CMD_LATCH  = 5'd2;
  localparam logic [4:0] CMD_LOAD   = 5'd3;
  localparam logic [4:0] CMD_ROW    = 5'd4;
  localparam logic [4:0] CMD_MRESET = 5'd5;
  localparam logic [4:0] CMD_OOR    = 5'd6;
  localparam logic [4:0] CMD_TICK   = 5'd7;
  localparam logic [4:0] CMD_F1     = 5'd8;
  localparam logic [4:0] CMD_F2     = 5'd9;
  localparam logic [4:0] CMD_RX     = 5'd10;
  localparam logic [4:0] CMD_RY     = 5'd11;
  localparam logic [4:0] CMD_EXEC   = 5'd12;
  localparam logic [4:0] CMD_RET    = 5'd13;
  localparam logic [4:0] CMD_DRAW_A = 5'd14;
  localparam logic [4:0] CMD_DRAW_B = 5'd15;
  localparam logic [4:0] CMD_BCD    = 5'd16;
  localparam logic [4:0] CMD_STORE  = 5'd17;
  localparam logic [4:0] CMD_LD_A   = 5'd18;
  localparam logic [4:0] CMD_LD_B   = 5'd19;
  localparam logic [4:0] CMD_PUSH   = 5'd20;

  typedef struct packed {
    logic [4:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic        clr_last;
    logic [1:0]  req;
    logic        pc_oor;
    logic [15:0] op;
    logic [3:0]  cnt;
    logic        sp_zero;
    logic        out_busy;
  } dp_stat_t;

  localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // reset content of one memory byte
  function automatic logic [7:0] boot_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < ADDR_W'(FONT_BYTES)) b = FONT[a[6:0]];
    return b;
  endfunction

endpackage

// File: src/c8ic_ctrl.sv
// sequencer of the chip-8 instruction core
// depends on c8ic_pkg
module c8ic_ctrl
  import c8ic_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_F1     = 5'd3;
  localparam logic [4:0] S_F2     = 5'd4;
  localparam logic [4:0] S_RX     = 5'd5;
  localparam logic [4:0] S_RY     = 5'd6;
  localparam logic [4:0] S_EXEC   = 5'd7;
  localparam logic [4:0] S_RET    = 5'd8;
  localparam logic [4:0] S_DRAW_A = 5'd9;
  localparam logic [4:0] S_DRAW_B = 5'd10;
  localparam logic [4:0] S_BCD    = 5'd11;
  localparam logic [4:0] S_STORE  = 5'd12;
  localparam logic [4:0] S_LD_A   = 5'd13;
  localparam logic [4:0] S_LD_B   = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  logic [4:0] state, state_next;
  logic [3:0] opx, opn;
  logic [7:0] opnn;

  assign opx  = stat.op[11:8];
  assign opn  = stat.op[3:0];
  assign opnn = stat.op[7:0];
  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd.code   = CMD_NOP;
    case (state)
      S_CLEAR: begin
        cmd.code = CMD_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.code   = CMD_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        case (stat.req)
          REQ_EXEC: begin
            if (stat.pc_oor) cmd.code = CMD_OOR;
            else begin
              cmd.code   = CMD_TICK;
              state_next = S_F1;
            end
          end
          REQ_LOAD: cmd.code = CMD_LOAD;
          REQ_ROW:  cmd.code = CMD_ROW;
          default:  cmd.code = CMD_MRESET;
        endcase
      end
      S_F1: begin
        cmd.code   = CMD_F1;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.code   = CMD_F2;
        state_next = S_RX;
      end
      S_RX: begin
        cmd.code   = CMD_RX;
        state_next = S_RY;
      end
      S_RY: begin
        cmd.code   = CMD_RY;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.code   = CMD_EXEC;
        state_next = S_DONE;
        if (stat.op == 16'h00EE && !stat.sp_zero) state_next = S_RET;
        if (stat.op[15:12] == 4'hD && opn != 4'h0) state_next = S_DRAW_A;
        if (stat.op[15:12] == 4'hF) begin
          if (opnn == 8'h33) state_next = S_BCD;
          if (opnn == 8'h55) state_next = S_STORE;
          if (opnn == 8'h65) state_next = S_LD_A;
        end
      end
      S_RET: begin
        cmd.code   = CMD_RET;
        state_next = S_DONE;
      end
      S_DRAW_A: begin
        cmd.code   = CMD_DRAW_A;
        state_next = S_DRAW_B;
      end
      S_DRAW_B: begin
        cmd.code   = CMD_DRAW_B;
        state_next = (stat.cnt == opn - 4'd1) ? S_DONE : S_DRAW_A;
      end
      S_BCD: begin
        cmd.code = CMD_BCD;
        if (stat.cnt == 4'd2) state_next = S_DONE;
      end
      S_STORE: begin
        cmd.code = CMD_STORE;
        if (stat.cnt == opx) state_next = S_DONE;
      end
      S_LD_A: begin
        cmd.code   = CMD_LD_A;
        state_next = S_LD_B;
      end
      S_LD_B: begin
        cmd.code   = CMD_LD_B;
        state_next = (stat.cnt == opx) ? S_DONE : S_LD_A;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.code   = CMD_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/c8ic_datapath.sv
// machine state, memories and execution units of the chip-8 core
// depends on c8ic_pkg
module c8ic_datapath
  import c8ic_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  input  logic [1:0]    in_req,
  input  logic [55:0]   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [87:0]   out_data
);

  // latched request
  logic [1:0]        q_req;
  logic [ADDR_W-1:0] q_addr;
  logic [7:0]        q_lbyte;
  logic [4:0]        q_row;
  logic [15:0]       q_keys;
  logic              q_tick;
  logic [7:0]        q_rnd;

  // architectural state
  logic [7:0]  mem [0:MEM_BYTES-1];
  logic [7:0]  mem_rdata;
  logic [7:0]  regs [0:15];
  logic [15:0] index;
  logic [15:0] pc;
  logic [15:0] stack [0:STACK_DEPTH-1];
  logic [15:0] stk_rdata;
  logic [CNT_W-1:0] sp;
  logic [63:0] frame [0:31];
  logic [7:0]  delay, sound;

  // working registers
  logic [ADDR_W-1:0] clr;
  logic [7:0]  hi, vx, vy;
  logic [15:0] op;
  logic [3:0]  cnt;
  logic        hit;
  logic [2:0]  r_status;
  logic        r_beep;
  logic [63:0] r_row;

  // datapath wires
  logic [ADDR_W-1:0] mem_raddr, mem_waddr, idx_addr;
  logic [7:0]  mem_wdata, reg_rd;
  logic        mem_we;
  logic [3:0]  reg_raddr, opx, opn;
  logic [7:0]  opnn;
  logic [11:0] nnn;
  logic [4:0]  frame_raddr;
  logic [63:0] frame_rd, sprite_mask;
  logic [127:0] sprite_dbl;
  logic        hit_now, push_call;
  logic [8:0]  add_sum;
  logic [7:0]  sub_xy, sub_yx;
  logic        key_dn;
  logic [3:0]  key_idx;
  logic        key_any;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_r;
  logic [14:0] bcd_p;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o, bcd_dig;

  assign opx  = op[11:8];
  assign opn  = op[3:0];
  assign opnn = op[7:0];
  assign nnn  = op[11:0];
  assign idx_addr = index[ADDR_W-1:0] + ADDR_W'(cnt);
  assign push_call = (cmd.code == CMD_EXEC) && (op[15:12] == 4'h2) &&
                     (sp != CNT_W'(STACK_DEPTH));

  // memory port selection
  always_comb begin
    mem_raddr = pc[ADDR_W-1:0];
    if (cmd.code == CMD_F1) mem_raddr = pc[ADDR_W-1:0] + ADDR_W'(1);
    if (cmd.code == CMD_DRAW_A || cmd.code == CMD_LD_A) mem_raddr = idx_addr;
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = reg_rd;
    case (cmd.code)
      CMD_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = boot_byte(clr);
      end
      CMD_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = q_addr;
        mem_wdata = q_lbyte;
      end
      CMD_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_dig;
      end
      CMD_STORE: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  // main memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // return stack, read ahead at the top entry
  always_ff @(posedge clk) begin
    if (push_call) stack[sp[SP_W-1:0]] <= pc;
    stk_rdata <= stack[SP_W'(sp - CNT_W'(1))];
  end

  // register file and frame read ports
  always_comb begin
    reg_raddr = cnt;
    if (cmd.code == CMD_RX) reg_raddr = opx;
    if (cmd.code == CMD_RY) reg_raddr = op[7:4];
  end
  assign reg_rd = regs[reg_raddr];
  assign frame_raddr = (cmd.code == CMD_ROW) ? q_row : 5'(vy[4:0] + {1'b0, cnt});
  assign frame_rd = frame[frame_raddr];

  // sprite row rotated into place
  assign sprite_dbl  = {mem_rdata, 56'b0, mem_rdata, 56'b0} >> vx[5:0];
  assign sprite_mask = sprite_dbl[63:0];
  assign hit_now     = |(frame_rd & sprite_mask);

  // alu helpers
  assign add_sum = {1'b0, vx} + {1'b0, vy};
  assign sub_xy  = vx - vy;
  assign sub_yx  = vy - vx;
  assign key_dn  = (vx[7:4] == 4'h0) && q_keys[vx[3:0]];

  // lowest pressed key
  always_comb begin
    key_idx = 4'h0;
    key_any = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (q_keys[k]) begin
        key_idx = 4'(k);
        key_any = 1'b1;
      end
    end
  end

  // decimal digits of vx
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 2'd2 : (vx >= 8'd100) ? 2'd1 : 2'd0;
    bcd_r = vx - ((bcd_h == 2'd2) ? 8'd200 : (bcd_h == 2'd1) ? 8'd100 : 8'd0);
    bcd_p = 15'(bcd_r) * 15'd205;
    bcd_t = bcd_p[14:11];
    bcd_o = bcd_r - ({bcd_t, 3'b0} + {3'b0, bcd_t, 1'b0});
    case (cnt)
      4'd0:    bcd_dig = {6'b0, bcd_h};
      4'd1:    bcd_dig = {4'b0, bcd_t};
      default: bcd_dig = bcd_o;
    endcase
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (cmd.code == CMD_CLEAR) clr <= clr + ADDR_W'(1);
  end

  // request latch and working registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_LATCH: begin
        q_req    <= in_req;
        q_addr   <= in_data[11:0];
        q_lbyte  <= in_data[19:12];
        q_row    <= in_data[24:20];
        q_keys   <= in_data[40:25];
        q_tick   <= in_data[41];
        q_rnd    <= in_data[49:42];
        r_status <= STAT_OK;
        r_beep   <= 1'b0;
        r_row    <= '0;
      end
      CMD_ROW: r_row <= frame_rd;
      CMD_OOR: r_status <= STAT_PC_RANGE;
      CMD_TICK: if (q_tick && sound != 8'd0) r_beep <= 1'b1;
      CMD_F1: hi <= mem_rdata;
      CMD_F2: op <= {hi, mem_rdata};
      CMD_RX: vx <= reg_rd;
      CMD_RY: begin
        vy  <= reg_rd;
        cnt <= 4'd0;
        hit <= 1'b0;
      end
      CMD_EXEC: begin
        case (op[15:12])
          4'h0: begin
            if (op == 16'h00EE) begin
              if (sp == '0) r_status <= STAT_UNDERFLOW;
            end else if (op != 16'h00E0) r_status <= STAT_MCALL;
          end
          4'h5, 4'h9: if (opn != 4'h0) r_status <= STAT_UNKNOWN;
          4'h8: begin
            if (opn inside {[4'h8:4'hD], 4'hF}) r_status <= STAT_UNKNOWN;
          end
          4'hE: if (opnn != 8'h9E && opnn != 8'hA1) r_status <= STAT_UNKNOWN;
          4'hF: begin
            if (!(opnn inside {8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                               8'h33, 8'h55, 8'h65})) r_status <= STAT_UNKNOWN;
          end
          default: r_status <= r_status;
        endcase
      end
      CMD_DRAW_B: begin
        hit <= hit | hit_now;
        cnt <= cnt + 4'd1;
      end
      CMD_BCD, CMD_STORE, CMD_LD_B: cnt <= cnt + 4'd1;
      default: cnt <= cnt;
    endcase
  end

  // machine state
  always_ff @(posedge clk) begin
    if (rst || cmd.code == CMD_MRESET) begin
      for (int i = 0; i < 16; i++) regs[i] <= 8'h00;
      for (int i = 0; i < 32; i++) frame[i] <= '0;
      index <= '0;
      pc    <= START_PC;
      sp    <= '0;
      delay <= 8'h00;
      sound <= 8'h00;
    end else begin
      case (cmd.code)
        CMD_TICK: begin
          if (q_tick) begin
            if (delay != 8'h00) delay <= delay - 8'd1;
            if (sound != 8'h00) sound <= sound - 8'd1;
          end
        end
        CMD_F2: pc <= pc + 16'd2;
        CMD_RET: pc <= stk_rdata;
        CMD_DRAW_B: begin
          frame[frame_raddr] <= frame_rd ^ sprite_mask;
          if (cnt == opn - 4'd1) regs[4'hF] <= {7'b0, hit | hit_now};
        end
        CMD_LD_B: regs[cnt] <= mem_rdata;
        CMD_EXEC: begin
          case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) begin
                for (int i = 0; i < 32; i++) frame[i] <= '0;
              end
              if (op == 16'h00EE && sp != '0) sp <= sp - CNT_W'(1);
            end
            4'h1: pc <= {4'h0, nnn};
            4'h2: begin
              if (push_call) sp <= sp + CNT_W'(1);
              pc <= {4'h0, nnn};
            end
            4'h3: if (vx == opnn) pc <= pc + 16'd2;
            4'h4: if (vx != opnn) pc <= pc + 16'd2;
            4'h5: if (opn == 4'h0 && vx == vy) pc <= pc + 16'd2;
            4'h6: regs[opx] <= opnn;
            4'h7: regs[opx] <= vx + opnn;
            4'h8: begin
              case (opn)
                4'h0: regs[opx] <= vy;
                4'h1: regs[opx] <= vx | vy;
                4'h2: regs[opx] <= vx & vy;
                4'h3: regs[opx] <= vx ^ vy;
                4'h4: begin
                  regs[4'hF] <= {7'b0, add_sum[8]};
                  regs[opx]  <= add_sum[7:0];
                end
                4'h5: begin
                  regs[4'hF] <= {7'b0, vx >= vy};
                  regs[opx]  <= sub_xy;
                end
                4'h6: begin
                  regs[4'hF] <= {7'b0, vy[0]};
                  regs[opx]  <= {1'b0, vy[7:1]};
                end
                4'h7: begin
                  regs[4'hF] <= {7'b0, vy >= vx};
                  regs[opx]  <= sub_yx;
                end
                4'hE: begin
                  regs[4'hF] <= {7'b0, vy[7]};
                  regs[opx]  <= {vy[6:0], 1'b0};
                end
                default: regs[opx] <= regs[opx];
              endcase
            end
            4'h9: if (opn == 4'h0 && vx != vy) pc <= pc + 16'd2;
            4'hA: index <= {4'h0, nnn};
            4'hB: pc <= {4'h0, nnn} + {8'h00, regs[0]};
            4'hC: regs[opx] <= opnn & q_rnd;
            4'hD: if (opn == 4'h0) regs[4'hF] <= 8'h00;
            4'hE: begin
              if (opnn == 8'h9E && key_dn) pc <= pc + 16'd2;
              if (opnn == 8'hA1 && !key_dn) pc <= pc + 16'd2;
            end
            default: begin
              case (opnn)
                8'h07: regs[opx] <= delay;
                8'h0A: begin
                  if (key_any) regs[opx] <= {4'h0, key_idx};
                  else pc <= pc - 16'd2;
                end
                8'h15: delay <= vx;
                8'h18: sound <= vx;
                8'h1E: index <= index + {8'h00, vx};
                8'h29: index <= {6'b0, vx, 2'b0} + {8'h00, vx};
                default: index <= index;
              endcase
            end
          endcase
        end
        default: pc <= pc;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.code == CMD_PUSH) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_PUSH) out_data <= {4'b0, r_beep, r_row, pc, r_status};
  end

  // status towards the sequencer
  assign stat.clr_last = (clr == '1);
  assign stat.req      = q_req;
  assign stat.pc_oor   = (pc[15:ADDR_W] != '0);
  assign stat.op       = op;
  assign stat.cnt      = cnt;
  assign stat.sp_zero  = (sp == '0);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// File: src/chip8_instruction_core.sv
// top level of the chip-8 instruction core
// depends on c8ic_pkg, c8ic_ctrl and c8ic_datapath
//
//  channel | direction | tuser          | tdata
//  s_axis  | in        | req_type       | load_address..random_byte
//  m_axis  | out       | (none)         | status, pc_after, display_bits, beep
//
// load, read and reset requests pass through dispatch to the result register
// execute steps through timer tick, two fetches, reads of vx and vy and execution
// (dispatch alone when pc is past memory), then a return, sprite rows, decimal
// store, stored registers or loaded registers; all through the one memory port
// after rst a sweep writes font and zeros to all memory, no beat accepted meanwhile
// a result waiting in the output register stalls only the end of the next request
module chip8_instruction_core
  import c8ic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  // [11:0] load_address, [19:12] load_byte, [24:20] display_row,
  // [40:25] pressed_keys, [41] timer_tick, [49:42] random_byte
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [18:3] pc_after, [82:19] display_bits, [83] beep
  output logic [87:0] m_axis_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  c8ic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  c8ic_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: src/c8ic_checker.sv
// port-level checks of chip8_instruction_core, bound to the top level
// depends on c8ic_pkg and chip8_instruction_core_defines.svh
`include "chip8_instruction_core_defines.svh"

module c8ic_checker
  import c8ic_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // a stalled result beat holds
  `C8_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one request at a time
  `C8_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accepting a beat")

  // status stays within its codes
  `C8_ASSERT_NOW(a_status, !m_axis_tvalid || m_axis_tdata[2:0] <= STAT_UNKNOWN, "status code out of range")

  // out-of-range report carries a pc beyond memory
  `C8_ASSERT_NOW(a_oor_pc, !(m_axis_tvalid && m_axis_tdata[2:0] == STAT_PC_RANGE) || m_axis_tdata[18:15] != 4'h0, "pc range status with pc inside memory")

endmodule

bind chip8_instruction_core c8ic_checker u_checker (.*);
